### rtl/rld_pkg.sv
// Shared types and constants of the RGB LED fade dimmer
package rld_pkg;

  localparam int LEVEL_WIDTH_DEF = 8;
  localparam int BYTE_W          = 8;
  localparam int COLOR_W         = 24;
  localparam int BRIGHT_W        = 4;
  localparam int FRAMES_W        = 6;
  localparam int CMD_W           = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 6;
  localparam int Q_DEPTH         = 2;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX_RST  = 4'd5;
  localparam logic [FRAMES_W-1:0] ANIM_FRAMES_RST = 6'd14;
  localparam logic                FADE_ENABLE_RST = 1'b1;
  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST  = 4'd5;
  localparam logic [COLOR_W-1:0]  COLOR_RST       = 24'h9C27B0;
  localparam logic [COLOR_W-1:0]  COLOR_BLACK     = 24'h000000;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_MAX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_ENABLE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_COLOR  = 3'd0,
    CMD_ON         = 3'd1,
    CMD_OFF        = 3'd2,
    CMD_TOGGLE     = 3'd3,
    CMD_SET_BRIGHT = 3'd4,
    CMD_UP         = 3'd5,
    CMD_DOWN       = 3'd6,
    CMD_WHITE      = 3'd7
  } cmd_t;

  typedef enum logic {
    OP_SHOW  = 1'b0,
    OP_WHITE = 1'b1
  } op_t;

  // One classified command as it waits between the front and the back
  typedef struct packed {
    op_t                 op;
    logic [COLOR_W-1:0]  rgb;
    logic [BRIGHT_W-1:0] brightness;
    logic                white;
  } job_t;

endpackage

### rtl/rld_if.sv
// Command and frame channel interfaces of the RGB LED fade dimmer
interface rld_cmd_if import rld_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [COLOR_W-1:0]  color;
  logic [BRIGHT_W-1:0] level;

  modport source (output valid, output cmd, output color, output level, input ready);
  modport sink   (input valid, input cmd, input color, input level, output ready);
endinterface

interface rld_frame_if import rld_pkg::*; #(parameter int LW = LEVEL_WIDTH_DEF) ();
  logic          valid;
  logic          ready;
  logic [LW-1:0] red;
  logic [LW-1:0] green;
  logic [LW-1:0] blue;
  logic [LW-1:0] white;
  logic          last;

  modport source (output valid, output red, output green, output blue, output white,
                  output last, input ready);
  modport sink   (input valid, input red, input green, input blue, input white,
                  input last, output ready);
endinterface

### rtl/rgb_led_fade_dimmer.sv
// Top level of the RGB LED fade dimmer: configuration registers and block wiring
//
// Each command transfer on in_ch produces one or more frame transfers on out_ch,
// the final one flagged with last. Set colour, on, off, toggle, set brightness,
// up and down compute a target level per channel as (colour byte / bright_max)
// times brightness, saturated at full scale; with fade_enable set and a nonzero
// anim_frames they first emit anim_frames intermediate frames stepping from the
// present levels towards the target, then the exact target frame. White toggle
// emits a single frame at once. A decoder at the front updates lamp, brightness,
// colour and white state as each command is accepted and queues a job (two deep);
// the frame generator behind it works through the queue, so commands are taken
// while frames are still stalled. One shared restoring divider, one quotient bit
// per cycle over max(8, LEVEL_WIDTH) bits, sets the pace: a colour job divides
// for the target of each channel and, when fading, for the fade step of each
// channel, then sends its frames, each held while out_ch is not ready. A white
// toggle needs no division. Configuration writes on cfg_* take effect at once
// and are meant for times when no command is in flight.
module rgb_led_fade_dimmer import rld_pkg::*; #(
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rld_cmd_if.sink               in_ch,
  rld_frame_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [BRIGHT_W-1:0] bright_max_r;
  logic [FRAMES_W-1:0] anim_frames_r;
  logic                fade_enable_r;

  // decoder to queue, queue to frame generator
  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  job_t q_job;
  logic q_valid;

  // register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_max_r  <= BRIGHT_MAX_RST;
      anim_frames_r <= ANIM_FRAMES_RST;
      fade_enable_r <= FADE_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BRIGHT_MAX:  bright_max_r  <= cfg_wdata[BRIGHT_W-1:0];
        CFG_ANIM_FRAMES: anim_frames_r <= cfg_wdata[FRAMES_W-1:0];
        CFG_FADE_ENABLE: fade_enable_r <= cfg_wdata[0];
        default: begin
          fade_enable_r <= fade_enable_r;
        end
      endcase
    end
  end

  // classify each command and advance the lamp state
  rld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .bright_max (bright_max_r),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // hold jobs so the decoder keeps taking transfers while frames stall
  rld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (q_job),
    .not_empty (q_valid)
  );

  // compute targets, fade steps and drive the frame channel
  rld_back #(.LEVEL_WIDTH(LEVEL_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .bright_max  (bright_max_r),
    .anim_frames (anim_frames_r),
    .fade_enable (fade_enable_r),
    .out_ch      (out_ch)
  );

endmodule

### rtl/rld_front.sv
// Command decoder: keeps lamp, brightness, colour and white state, queues jobs
module rld_front import rld_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  rld_cmd_if.sink             in_ch,
  input  logic [BRIGHT_W-1:0] bright_max,
  input  logic                q_full,
  output logic                push,
  output job_t                push_job
);

  logic                lamp_on_r, lamp_on_nxt;
  logic [BRIGHT_W-1:0] brightness_r, brightness_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic                white_on_r, white_on_nxt;
  logic [BRIGHT_W:0]   bright_inc;
  op_t                 op;
  logic [COLOR_W-1:0]  rgb;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    lamp_on_nxt    = lamp_on_r;
    brightness_nxt = brightness_r;
    color_nxt      = color_r;
    white_on_nxt   = white_on_r;
    op             = OP_SHOW;
    rgb            = color_r;
    bright_inc     = {1'b0, brightness_r} + (BRIGHT_W+1)'(1);
    unique case (cmd_t'(in_ch.cmd))
      CMD_SET_COLOR: begin
        rgb = in_ch.color;
        // black shows dark but keeps the remembered colour
        if (in_ch.color != COLOR_BLACK) begin
          color_nxt = in_ch.color;
        end
      end
      CMD_ON: begin
        lamp_on_nxt = 1'b1;
      end
      CMD_OFF: begin
        lamp_on_nxt = 1'b0;
        rgb         = COLOR_BLACK;
      end
      CMD_TOGGLE: begin
        lamp_on_nxt = !lamp_on_r;
        if (lamp_on_r) begin
          rgb = COLOR_BLACK;
        end
      end
      CMD_SET_BRIGHT: begin
        brightness_nxt = in_ch.level;
      end
      CMD_UP: begin
        if (bright_inc >= {1'b0, bright_max}) begin
          brightness_nxt = bright_max;
        end else begin
          brightness_nxt = bright_inc[BRIGHT_W-1:0];
        end
      end
      CMD_DOWN: begin
        if (brightness_r <= BRIGHT_W'(2)) begin
          brightness_nxt = BRIGHT_W'(1);
        end else begin
          brightness_nxt = brightness_r - BRIGHT_W'(1);
        end
      end
      CMD_WHITE: begin
        white_on_nxt = !white_on_r;
        op           = OP_WHITE;
      end
      default: begin
        op = OP_SHOW;
      end
    endcase
    push_job.op         = op;
    push_job.rgb        = rgb;
    push_job.brightness = brightness_nxt;
    push_job.white      = white_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_on_r    <= 1'b1;
      brightness_r <= BRIGHTNESS_RST;
      color_r      <= COLOR_RST;
      white_on_r   <= 1'b0;
    end else if (push) begin
      lamp_on_r    <= lamp_on_nxt;
      brightness_r <= brightness_nxt;
      color_r      <= color_nxt;
      white_on_r   <= white_on_nxt;
    end
  end

endmodule

### rtl/rld_queue.sv
// Short job queue between the command decoder and the frame generator
module rld_queue import rld_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic not_empty
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  job_t            slot_r [Q_DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [CW-1:0]   cnt_r;

  assign full      = (cnt_r == CW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(Q_DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

### rtl/rld_div.sv
// Restoring divider, one quotient bit per cycle
module rld_div #(
  parameter int DW = 8,
  parameter int VW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] d_r;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;
  logic          fits;

  assign shifted  = {rem_r, q_r[DW-1]};
  assign trial    = shifted - {1'b0, d_r};
  assign fits     = (shifted >= {1'b0, d_r});
  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        q_r    <= dividend;
        rem_r  <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[DW-2:0], fits};
        rem_r <= fits ? trial[VW-1:0] : shifted[VW-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/rld_back.sv
// Frame generator: target levels, fade steps and frame output
module rld_back import rld_pkg::*; #(
  parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  job_t                q_job,
  output logic                q_pop,
  input  logic [BRIGHT_W-1:0] bright_max,
  input  logic [FRAMES_W-1:0] anim_frames,
  input  logic                fade_enable,
  rld_frame_if.source         out_ch
);

  localparam int W      = LEVEL_WIDTH;
  localparam int DW     = (W > BYTE_W) ? W : BYTE_W;
  localparam int PRODW  = BYTE_W + BRIGHT_W;
  localparam int SW     = (W > PRODW) ? W : PRODW;
  localparam int NCH    = 3;

  typedef enum logic [2:0] {
    S_IDLE, S_TDIV, S_TWAIT, S_FDIV, S_FWAIT, S_FRAME, S_LAST, S_WHITE
  } state_t;

  state_t              state_r;
  logic [1:0]          ch_r;
  logic [FRAMES_W-1:0] cnt_r;
  job_t                job_r;
  logic [W-1:0]        level_r [NCH];
  logic [W-1:0]        tgt_r   [NCH];
  logic [W-1:0]        cur_r   [NCH];
  logic [W-1:0]        step_r  [NCH];
  logic                neg_r   [NCH];
  logic                out_valid_r;
  logic [W-1:0]        out_red_r;
  logic [W-1:0]        out_green_r;
  logic [W-1:0]        out_blue_r;
  logic [W-1:0]        out_white_r;
  logic                out_last_r;

  logic                slot_free;
  logic [BYTE_W-1:0]   byte_sel;
  logic [BRIGHT_W-1:0] bm_eff;
  logic [PRODW-1:0]    prod;
  logic [SW-1:0]       prod_ext;
  logic [W-1:0]        sat;
  logic [W:0]          diff;
  logic [W-1:0]        mag;
  logic [W-1:0]        cur_nxt [NCH];
  logic [W-1:0]        white_lvl;
  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [FRAMES_W-1:0] div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [DW-1:0]       div_q;

  rld_div #(.DW(DW), .VW(FRAMES_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign white_lvl = job_r.white ? {W{1'b1}} : '0;

  always_comb begin
    case (ch_r)
      2'd0:    byte_sel = job_r.rgb[23:16];
      2'd1:    byte_sel = job_r.rgb[15:8];
      default: byte_sel = job_r.rgb[7:0];
    endcase
    bm_eff   = (bright_max == '0) ? BRIGHT_W'(1) : bright_max;
    prod     = div_q[BYTE_W-1:0] * job_r.brightness;
    prod_ext = SW'(prod);
    sat      = (prod_ext > SW'({W{1'b1}})) ? {W{1'b1}} : prod_ext[W-1:0];
    diff     = {1'b0, level_r[ch_r]} - {1'b0, tgt_r[ch_r]};
    mag      = diff[W] ? (~diff[W-1:0] + W'(1)) : diff[W-1:0];
    for (int c = 0; c < NCH; c++) begin
      cur_nxt[c] = neg_r[c] ? cur_r[c] + step_r[c] : cur_r[c] - step_r[c];
    end
    div_start    = (state_r == S_TDIV) || (state_r == S_FDIV);
    div_dividend = (state_r == S_FDIV) ? DW'(mag) : DW'(byte_sel);
    div_divisor  = (state_r == S_FDIV) ? anim_frames : FRAMES_W'(bm_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        level_r[c] <= '0;
      end
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            job_r   <= q_job;
            ch_r    <= '0;
            state_r <= (q_job.op == OP_WHITE) ? S_WHITE : S_TDIV;
          end
        end
        S_TDIV: begin
          state_r <= S_TWAIT;
        end
        S_TWAIT: begin
          if (div_done) begin
            tgt_r[ch_r] <= sat;
            if (ch_r == 2'd2) begin
              ch_r    <= '0;
              state_r <= (fade_enable && anim_frames != '0) ? S_FDIV : S_LAST;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= S_TDIV;
            end
          end
        end
        S_FDIV: begin
          neg_r[ch_r] <= diff[W];
          cur_r[ch_r] <= level_r[ch_r];
          state_r     <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            step_r[ch_r] <= div_q[W-1:0];
            if (ch_r == 2'd2) begin
              cnt_r   <= FRAMES_W'(1);
              state_r <= S_FRAME;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= S_FDIV;
            end
          end
        end
        S_FRAME: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_red_r   <= cur_nxt[0];
            out_green_r <= cur_nxt[1];
            out_blue_r  <= cur_nxt[2];
            out_white_r <= white_lvl;
            out_last_r  <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
              cur_r[c] <= cur_nxt[c];
            end
            if (cnt_r == anim_frames) begin
              state_r <= S_LAST;
            end else begin
              cnt_r <= cnt_r + FRAMES_W'(1);
            end
          end
        end
        S_LAST: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_red_r   <= tgt_r[0];
            out_green_r <= tgt_r[1];
            out_blue_r  <= tgt_r[2];
            out_white_r <= white_lvl;
            out_last_r  <= 1'b1;
            for (int c = 0; c < NCH; c++) begin
              level_r[c] <= tgt_r[c];
            end
            state_r <= S_IDLE;
          end
        end
        S_WHITE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_red_r   <= level_r[0];
            out_green_r <= level_r[1];
            out_blue_r  <= level_r[2];
            out_white_r <= white_lvl;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;
  assign out_ch.white = out_white_r;
  assign out_ch.last  = out_last_r;

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job taken from an empty queue");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRAME) |-> (cnt_r != '0 && cnt_r <= anim_frames))
    else $error("fade frame count out of range");

  a_final_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LAST && slot_free) |=> (out_valid_r && out_last_r))
    else $error("final frame not presented with last");

  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LAST) |=>
      ($stable(level_r[0]) && $stable(level_r[1]) && $stable(level_r[2])))
    else $error("channel levels changed before the final frame");

endmodule
